// ===== hw/rtl/kli_pkg.sv =====
// shared types, codes and constants of the keyframe interpolator
package kli_pkg;

	localparam int MAX_KEYS_DEF  = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SEG_W         = 6;
	localparam int TIME_W        = 34;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SET = 2'd1;
	localparam logic [1:0] FUNC_ADV = 2'd2;
	localparam logic [1:0] FUNC_NOP = 2'd3;

	localparam logic [1:0] STAT_INTERP = 2'd0;
	localparam logic [1:0] STAT_HELD   = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;
	localparam logic [1:0] STAT_NOSEG  = 2'd3;

	localparam logic REG_COMPONENTS = 1'b0;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] time_value;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
		logic [SEG_W-1:0]   segment_index;
		logic [1:0]         status;
	} out_beat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_WCHK, S_WDIV, S_EVAL, S_SCAN, S_FCHK,
		S_FDIV, S_RDA, S_RDB, S_MUL, S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic add;
		logic set_full;
		logic calc_t;
		logic wrap_start;
		logic pt_direct;
		logic wrap_apply;
		logic eval;
		logic scan;
		logic fchk;
		logic frac_ld;
		logic rda;
		logic rdb;
		logic mul;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       full;
		logic       usable;
		logic       outside;
		logic       div_done;
		logic       hit;
		logic       miss;
		logic       dzero;
		logic       out_busy;
	} dp_stat_t;

endpackage

// ===== hw/rtl/kli_div.sv =====
// restoring long divider, one quotient bit per cycle
module kli_div #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [31:0]   remainder
);
	localparam int CNTW = $clog2(DW + 1);

	logic [31:0]     rem_q;
	logic [DW-1:0]   quo_q;
	logic [31:0]     dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [32:0]     trial;
	logic [32:0]     diff;
	logic            take;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
		take  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[DW-2:0], take};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/kli_ctrl.sv =====
// sequencer of the keyframe interpolator
module kli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kli_pkg::dp_stat_t stat,
	output kli_pkg::dp_cmd_t  cmd
);
	import kli_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (stat.func == FUNC_ADD) begin
					state_d = S_EVAL;
				end else if ((stat.func inside {FUNC_SET, FUNC_ADV}) && stat.usable) begin
					state_d = S_WCHK;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_WCHK:   state_d = stat.outside ? S_WDIV : S_EVAL;
			S_WDIV:   if (stat.div_done) state_d = S_EVAL;
			S_EVAL:   state_d = stat.usable ? S_SCAN : S_RDA;
			S_SCAN: begin
				if (stat.hit) begin
					state_d = S_FCHK;
				end else if (stat.miss) begin
					state_d = S_RDA;
				end
			end
			S_FCHK:   state_d = stat.dzero ? S_RDA : S_FDIV;
			S_FDIV:   if (stat.div_done) state_d = S_RDA;
			S_RDA:    state_d = S_RDB;
			S_RDB:    state_d = S_MUL;
			S_MUL:    state_d = S_FIN;
			S_FIN:    if (!stat.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: begin
				if (stat.func == FUNC_ADD) begin
					cmd.set_full = stat.full;
					cmd.add      = !stat.full;
				end else if ((stat.func inside {FUNC_SET, FUNC_ADV}) && stat.usable) begin
					cmd.calc_t = 1'b1;
				end
			end
			S_WCHK: begin
				cmd.wrap_start = stat.outside;
				cmd.pt_direct  = !stat.outside;
			end
			S_WDIV:   cmd.wrap_apply = stat.div_done;
			S_EVAL:   cmd.eval = 1'b1;
			S_SCAN:   cmd.scan = 1'b1;
			S_FCHK:   cmd.fchk = 1'b1;
			S_FDIV:   cmd.frac_ld = stat.div_done;
			S_RDA:    cmd.rda = 1'b1;
			S_RDB:    cmd.rdb = 1'b1;
			S_MUL:    cmd.mul = 1'b1;
			S_FIN:    cmd.fin = !stat.out_busy;
			default:  cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/kli_dp.sv =====
// datapath: key table, span and time registers, wrap, search and blend
module kli_dp #(
	parameter int MAX_KEYS  = kli_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kli_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kli_pkg::in_beat_t  in_data,
	output kli_pkg::out_beat_t out_data,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         components,
	input  kli_pkg::dp_cmd_t   cmd,
	output kli_pkg::dp_stat_t  stat
);
	import kli_pkg::*;

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int DW = 32 + FRAC_BITS;
	localparam int FW = FRAC_BITS + 1;
	localparam int PW = 33 + FW + 1;

	logic signed [31:0] mem_t [MAX_KEYS];
	logic signed [31:0] mem_x [MAX_KEYS];
	logic signed [31:0] mem_y [MAX_KEYS];
	logic signed [31:0] mem_z [MAX_KEYS];

	in_beat_t           item_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] start_q, end_q, pt_q;
	logic signed [TIME_W-1:0] tcalc_q;
	logic               above_q;
	logic               full_q, hold_q, zero_q;
	logic [1:0]         st_q;
	logic [AW-1:0]      seg_q;
	logic [CW-1:0]      kidx_q;
	logic signed [31:0] prev_q, t0_q, t1_q;
	logic [FW-1:0]      f_q;
	logic signed [31:0] rt_q, rx_q, ry_q, rz_q;
	logic signed [31:0] ax_q, ay_q, az_q;
	logic signed [PW-1:0] px_q, py_q, pz_q;
	out_beat_t          out_q;
	logic               out_valid_q;

	logic [AW-1:0]      rd_addr;
	logic [CW-1:0]      knext;
	logic [AW-1:0]      seg_next;
	logic signed [TIME_W-1:0] start_x, end_x;
	logic [TIME_W-1:0]  wdist;
	logic [DW-1:0]      div_dividend;
	logic [31:0]        div_divisor;
	logic               div_start, div_done;
	logic [DW-1:0]      div_quo;
	logic [31:0]        div_rem;
	logic signed [31:0] wrap_val;
	logic               usable, above, below;
	logic signed [31:0] new_start, new_end;
	logic signed [32:0] dx, dy, dz;
	logic signed [FW:0] f_s;
	logic signed [PW-1:0] sx, sy, sz;

	always_comb begin
		usable  = (count_q > CW'(1)) && (end_q > start_q);
		start_x = TIME_W'(start_q);
		end_x   = TIME_W'(end_q);
		above   = tcalc_q > end_x;
		below   = tcalc_q < start_x;
		wdist   = above ? (tcalc_q - end_x) : (start_x - tcalc_q);
		knext   = kidx_q + CW'(1);
		seg_next = seg_q + AW'(1);
		if (cmd.scan) begin
			rd_addr = knext[AW-1:0];
		end else if (cmd.rda) begin
			rd_addr = seg_q;
		end else if (cmd.rdb) begin
			rd_addr = hold_q ? seg_q : seg_next;
		end else begin
			rd_addr = '0;
		end
		if (count_q == '0) begin
			new_start = item_q.time_value;
			new_end   = item_q.time_value;
		end else begin
			new_start = (item_q.time_value < start_q) ? item_q.time_value : start_q;
			new_end   = (item_q.time_value > end_q) ? item_q.time_value : end_q;
		end
		if (above_q) begin
			wrap_val = (div_rem == '0) ? end_q : start_q + $signed(div_rem);
		end else begin
			wrap_val = (div_rem == '0) ? start_q : end_q - $signed(div_rem);
		end
		div_start = cmd.wrap_start || (cmd.fchk && (t1_q == t0_q) == 1'b0);
		if (cmd.wrap_start) begin
			div_dividend = DW'(wdist);
			div_divisor  = end_q - start_q;
		end else begin
			div_dividend = {pt_q - t0_q, {FRAC_BITS{1'b0}}};
			div_divisor  = t1_q - t0_q;
		end
		dx  = 33'(rx_q) - 33'(ax_q);
		dy  = 33'(ry_q) - 33'(ay_q);
		dz  = 33'(rz_q) - 33'(az_q);
		f_s = $signed({1'b0, f_q});
		sx  = px_q >>> FRAC_BITS;
		sy  = py_q >>> FRAC_BITS;
		sz  = pz_q >>> FRAC_BITS;
	end

	kli_div #(.DW(DW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// key table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			mem_t[count_q[AW-1:0]] <= item_q.time_value;
			mem_x[count_q[AW-1:0]] <= item_q.key_x;
			mem_y[count_q[AW-1:0]] <= item_q.key_y;
			mem_z[count_q[AW-1:0]] <= item_q.key_z;
		end
		rt_q <= mem_t[rd_addr];
		rx_q <= mem_x[rd_addr];
		ry_q <= mem_y[rd_addr];
		rz_q <= mem_z[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			start_q     <= '0;
			end_q       <= '0;
			pt_q        <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) full_q <= 1'b0;
			if (cmd.set_full) full_q <= 1'b1;
			if (cmd.add) begin
				count_q <= count_q + CW'(1);
				start_q <= new_start;
				end_q   <= new_end;
				pt_q    <= new_start;
			end
			if (cmd.pt_direct) pt_q <= tcalc_q[31:0];
			if (cmd.wrap_apply) pt_q <= wrap_val;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		if (cmd.calc_t) begin
			if (item_q.func == FUNC_SET) begin
				tcalc_q <= TIME_W'(item_q.time_value);
			end else begin
				tcalc_q <= TIME_W'(pt_q) + TIME_W'(item_q.time_value);
			end
		end
		if (cmd.wrap_start) above_q <= above;
		if (cmd.eval) begin
			kidx_q <= '0;
			zero_q <= (count_q == '0);
			if (!usable) begin
				seg_q  <= '0;
				f_q    <= '0;
				st_q   <= STAT_HELD;
				hold_q <= 1'b1;
			end
		end
		if (cmd.scan) begin
			kidx_q <= knext;
			prev_q <= rt_q;
			if (stat.hit) begin
				seg_q  <= AW'(kidx_q - CW'(1));
				t0_q   <= prev_q;
				t1_q   <= rt_q;
				st_q   <= STAT_INTERP;
				hold_q <= 1'b0;
			end else if (stat.miss) begin
				seg_q  <= '0;
				f_q    <= '0;
				st_q   <= STAT_NOSEG;
				hold_q <= 1'b1;
			end
		end
		if (cmd.fchk && t1_q == t0_q) f_q <= '0;
		if (cmd.frac_ld) f_q <= div_quo[FW-1:0];
		if (cmd.rdb) begin
			ax_q <= rx_q;
			ay_q <= ry_q;
			az_q <= rz_q;
		end
		if (cmd.mul) begin
			px_q <= dx * f_s;
			py_q <= dy * f_s;
			pz_q <= dz * f_s;
		end
		if (cmd.fin) begin
			out_q.value_x       <= (zero_q || components < 2'd1) ? '0 : ax_q + sx[31:0];
			out_q.value_y       <= (zero_q || components < 2'd2) ? '0 : ay_q + sy[31:0];
			out_q.value_z       <= (zero_q || components < 2'd3) ? '0 : az_q + sz[31:0];
			out_q.segment_index <= SEG_W'(seg_q);
			out_q.status        <= full_q ? STAT_FULL : st_q;
		end
	end

	always_comb begin
		stat          = '0;
		stat.func     = item_q.func;
		stat.full     = (count_q == CW'(MAX_KEYS));
		stat.usable   = usable;
		stat.outside  = above || below;
		stat.div_done = div_done;
		stat.hit      = (kidx_q != '0) && (prev_q <= pt_q) && (pt_q <= rt_q);
		stat.miss     = !stat.hit && (kidx_q == count_q - CW'(1));
		stat.dzero    = (t1_q == t0_q);
		stat.out_busy = out_valid_q && !out_ready;
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/keyframe_linear_interpolator.sv =====
// one item at a time from accept to result
// the time wrap and the segment fraction each use the serial divider
// the segment search reads one key time per cycle from the key table
// a new item can be taken in the same cycle that the result sits in the output register
// reset clears key count, span and playback time; key table contents are not cleared
module keyframe_linear_interpolator #(
	parameter int MAX_KEYS  = kli_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kli_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  kli_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output kli_pkg::out_beat_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import kli_pkg::*;

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [1:0] comp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q <= 2'd3;
		end else if (psel && penable && pwrite && paddr[2] == REG_COMPONENTS) begin
			comp_q <= pwdata[1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COMPONENTS) ? {30'd0, comp_q} : 32'd0;

	kli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kli_dp #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.out_data   (out_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.components (comp_q),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

// ===== hw/rtl/kli_chk.sv =====
// port-level checks of the keyframe interpolator, bound to the top level
module kli_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input kli_pkg::in_beat_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input kli_pkg::out_beat_t out_data,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [2:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready
);
	import kli_pkg::*;

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// one item in flight: no second accept right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// held or unmatched results point at the first key
	a_seg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STAT_HELD || out_data.status == STAT_NOSEG)
		|-> out_data.segment_index == '0)
		else $error("nonzero segment on held result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port stalled");

endmodule

bind keyframe_linear_interpolator kli_chk u_kli_chk (.*);
